// ----- src/rtpiep_pkg.sv -----
package rtpiep_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
  // largest header: 12 + 15 CSRC words + 4 + 65535 extension words
  localparam int HL_W = 19;

  localparam int FIXED_HDR = 12;
  localparam int EVENT_BYTES = 21;
  localparam int MIN_BYTES = FIXED_HDR + EVENT_BYTES;
  localparam int HDR_BYTES = 10;
  localparam int HDR_AW = $clog2(HDR_BYTES);
  localparam int PAY_AW = $clog2(EVENT_BYTES);
  localparam int RTP_VERSION = 2;

  localparam logic [7:0] CSRC_MASK = 8'h0F;
  localparam logic [7:0] EXT_MASK = 8'h10;
  localparam logic [7:0] PAD_MASK = 8'h20;
  localparam logic [1:0] VER_MASK = 2'h3;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [15:0]        sequence_res;
    logic [31:0]        media_ts;
    logic [31:0]        ssrc;
    logic [7:0]         evt_kind;
    logic [15:0]        norm_x;
    logic [15:0]        norm_y;
    logic [7:0]         btn_mask;
    logic signed [15:0] wheel_delta;
    logic [7:0]         mod_mask;
    logic [31:0]        key_val;
    logic [63:0]        sent_ms;
  } out_t;

  // packet state as it stands after its final word
  typedef struct packed {
    logic [IDX_W-1:0]                 size;
    logic [7:0]                       first_header_byte;
    logic [15:0]                      extension_words;
    logic [7:0]                       pad_byte;
    logic [HDR_BYTES-1:0][7:0]        header_fields;
    logic [EVENT_BYTES-1:0][7:0]      payload;
  } snap_t;

  function automatic logic [HL_W-1:0] base_length(logic [7:0] b0);
    return HL_W'(FIXED_HDR) + HL_W'({b0 & CSRC_MASK, 2'b00});
  endfunction

endpackage

// ----- src/rtp_input_event_parser_unit.sv -----
// RTP input-event parser. Takes one packet byte per word on the input channel, the
// final byte of a packet marked by last_byte, and gives one result word per packet:
// the RTP sequence number, timestamp and SSRC plus the 21-byte input event that
// follows the header (CSRC list and header extension skipped, padding removed).
// A packet shorter than 33 bytes, not version 2, with header or extension running
// past its end, or with bad padding yields ok = 0 and all fields zero. Bytes past
// MAX_PACKET_BYTES are dropped. A new byte is accepted every clock cycle while in_ready
// is high. The accepting edge captures the packet state into the snapshot register;
// out_valid rises when the checked result is then registered from it. Two finished packets
// can be held while the output is stalled; once both wait, the input stalls too.
module rtp_input_event_parser_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rtpiep_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rtpiep_pkg::out_t  out_data
);

  logic take, done;
  rtpiep_pkg::snap_t snap_new, snap;
  logic snap_valid;
  logic out_free, snap_move;
  rtpiep_pkg::out_t result;

  logic [rtpiep_pkg::HL_W-1:0] size_w, base, hl_ext, hl, pend, pad_w;
  logic ext, pad_en, ok;
  logic [7:0] fhb;

  assign out_free = !out_valid || out_ready;
  assign snap_move = snap_valid && out_free;
  assign in_ready = !snap_valid || out_free;
  assign take = in_valid && in_ready;

  rtpiep_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_word (in_data),
    .done    (done),
    .snap    (snap_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (done) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      snap <= snap_new;
    end
  end

  always_comb begin
    fhb = snap.first_header_byte;
    size_w = rtpiep_pkg::HL_W'(snap.size);
    pad_w = rtpiep_pkg::HL_W'(snap.pad_byte);
    base = rtpiep_pkg::base_length(fhb);
    ext = |(fhb & rtpiep_pkg::EXT_MASK);
    pad_en = |(fhb & rtpiep_pkg::PAD_MASK);
    hl_ext = base + rtpiep_pkg::HL_W'(4) + rtpiep_pkg::HL_W'({snap.extension_words, 2'b00});
    hl = ext ? hl_ext : base;
    pend = pad_en ? size_w - pad_w : size_w;

    ok = 1'b1;
    if (size_w < rtpiep_pkg::HL_W'(rtpiep_pkg::MIN_BYTES)) ok = 1'b0;
    if (((fhb[7:6]) & rtpiep_pkg::VER_MASK) != 2'(rtpiep_pkg::RTP_VERSION)) ok = 1'b0;
    if (base > size_w) ok = 1'b0;
    if (ext && (base + rtpiep_pkg::HL_W'(4) > size_w || hl_ext > size_w)) ok = 1'b0;
    // size >= hl holds whenever the checks above passed
    if (pad_en && (pad_w == '0 || pad_w > size_w - hl)) ok = 1'b0;
    if (pend < hl + rtpiep_pkg::HL_W'(rtpiep_pkg::EVENT_BYTES)) ok = 1'b0;

    result = '0;
    if (ok) begin
      result.ok = 1'b1;
      result.sequence_res = {snap.header_fields[0], snap.header_fields[1]};
      result.media_ts = {snap.header_fields[2], snap.header_fields[3],
                         snap.header_fields[4], snap.header_fields[5]};
      result.ssrc = {snap.header_fields[6], snap.header_fields[7],
                     snap.header_fields[8], snap.header_fields[9]};
      result.evt_kind = snap.payload[0];
      result.norm_x = {snap.payload[1], snap.payload[2]};
      result.norm_y = {snap.payload[3], snap.payload[4]};
      result.btn_mask = snap.payload[5];
      result.wheel_delta = $signed({snap.payload[6], snap.payload[7]});
      result.mod_mask = snap.payload[8];
      result.key_val = {snap.payload[9], snap.payload[10], snap.payload[11],
                        snap.payload[12]};
      result.sent_ms = {snap.payload[13], snap.payload[14], snap.payload[15],
                        snap.payload[16], snap.payload[17], snap.payload[18],
                        snap.payload[19], snap.payload[20]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      out_data <= result;
    end
  end

endmodule

// ----- src/rtpiep_capture.sv -----
module rtpiep_capture (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  rtpiep_pkg::in_t     in_word,
  output logic                done,
  output rtpiep_pkg::snap_t   snap
);

  logic [rtpiep_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0] first_header_byte, first_header_byte_next;
  logic [rtpiep_pkg::HL_W-1:0] header_length, header_length_next;
  logic [15:0] extension_words, extension_words_next;
  logic [7:0] last_kept_byte, last_kept_byte_next;
  logic [rtpiep_pkg::HDR_BYTES-1:0][7:0] header_fields, header_fields_next;
  logic [rtpiep_pkg::EVENT_BYTES-1:0][7:0] payload_store, payload_store_next;

  logic keep;
  logic ext;
  logic [7:0] b;
  logic [rtpiep_pkg::HL_W-1:0] base, hl_cur, i_w, pay_off;
  logic [rtpiep_pkg::IDX_W-1:0] hdr_off;

  assign b = in_word.packet_byte;
  assign keep = byte_index < rtpiep_pkg::IDX_W'(rtpiep_pkg::MAX_PACKET_BYTES);
  assign i_w = rtpiep_pkg::HL_W'(byte_index);
  assign hdr_off = byte_index - rtpiep_pkg::IDX_W'(2);

  always_comb begin
    first_header_byte_next = first_header_byte;
    header_length_next = header_length;
    extension_words_next = extension_words;
    last_kept_byte_next = last_kept_byte;
    header_fields_next = header_fields;
    payload_store_next = payload_store;
    byte_index_next = byte_index;

    if (keep && byte_index == '0) begin
      first_header_byte_next = b;
    end
    base = rtpiep_pkg::base_length(first_header_byte_next);
    ext = |(first_header_byte_next & rtpiep_pkg::EXT_MASK);
    hl_cur = (byte_index == '0) ? base : header_length;
    pay_off = i_w - hl_cur;

    if (keep) begin
      header_length_next = hl_cur;
      if (i_w >= rtpiep_pkg::HL_W'(2) && i_w < rtpiep_pkg::HL_W'(rtpiep_pkg::FIXED_HDR)) begin
        header_fields_next[hdr_off[rtpiep_pkg::HDR_AW-1:0]] = b;
      end
      if (ext && i_w == base + rtpiep_pkg::HL_W'(2)) begin
        extension_words_next = {b, 8'h00};
      end
      if (ext && i_w == base + rtpiep_pkg::HL_W'(3)) begin
        extension_words_next = {extension_words[15:8], b};
        header_length_next = base + rtpiep_pkg::HL_W'(4)
                           + rtpiep_pkg::HL_W'({extension_words_next, 2'b00});
      end
      // payload offset uses the header length already settled before this word
      if ((!ext || i_w > base + rtpiep_pkg::HL_W'(3)) && i_w >= hl_cur
          && pay_off < rtpiep_pkg::HL_W'(rtpiep_pkg::EVENT_BYTES)) begin
        payload_store_next[pay_off[rtpiep_pkg::PAY_AW-1:0]] = b;
      end
      last_kept_byte_next = b;
      byte_index_next = byte_index + rtpiep_pkg::IDX_W'(1);
    end
  end

  assign done = take && in_word.last_byte;

  always_comb begin
    snap.size = byte_index_next;
    snap.first_header_byte = first_header_byte_next;
    snap.extension_words = extension_words_next;
    snap.pad_byte = last_kept_byte_next;
    snap.header_fields = header_fields_next;
    snap.payload = payload_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      first_header_byte <= '0;
      header_length <= '0;
      extension_words <= '0;
      last_kept_byte <= '0;
    end else if (take) begin
      if (in_word.last_byte) begin
        byte_index <= '0;
        first_header_byte <= '0;
        header_length <= '0;
        extension_words <= '0;
        last_kept_byte <= '0;
      end else begin
        byte_index <= byte_index_next;
        first_header_byte <= first_header_byte_next;
        header_length <= header_length_next;
        extension_words <= extension_words_next;
        last_kept_byte <= last_kept_byte_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      header_fields <= header_fields_next;
      payload_store <= payload_store_next;
    end
  end

endmodule
